// ----- sv/bpv_pkg.sv -----
// Shared types, constants and discharge tables of the battery percentage unit.
package bpv_pkg;

    localparam int VOLTAGE_BITS_DEFAULT = 13;
    localparam int VCMP_BITS            = 16;
    localparam int TVOLT_BITS           = 13;
    localparam int UNIT_BITS            = 10;
    localparam int IDX_BITS             = 5;
    localparam int LEFT_COUNT           = 13;
    localparam int RIGHT_COUNT          = 17;
    localparam int CFG_INDEX_BITS       = 2;
    localparam int CFG_DATA_BITS        = 13;
    localparam int PCT_BITS             = 7;
    localparam int DIVIDEND_BITS        = 18;
    localparam int DIVISOR_BITS         = 11;
    localparam int FACTOR_BITS          = 8;

    localparam logic [CFG_DATA_BITS-1:0] FULL_VOLTAGE_RESET  = 13'd4150;
    localparam logic [CFG_DATA_BITS-1:0] EMPTY_VOLTAGE_RESET = 13'd3000;

    localparam logic [PCT_BITS-1:0] PCT_MIN   = 7'd1;
    localparam logic [PCT_BITS-1:0] PCT_MID   = 7'd50;
    localparam logic [PCT_BITS-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_BITS-1:0] PCT_SCALE = 7'd99;

    localparam logic [TVOLT_BITS-1:0] LEFT_VOLTS [LEFT_COUNT] = '{
        13'd4288, 13'd4022, 13'd3998, 13'd3950, 13'd3859, 13'd3818, 13'd3771,
        13'd3629, 13'd3496, 13'd3420, 13'd3317, 13'd3168, 13'd1678 };
    localparam logic [UNIT_BITS-1:0] LEFT_UNITS [LEFT_COUNT] = '{
        10'd0, 10'd200, 10'd218, 10'd248, 10'd298, 10'd338, 10'd378,
        10'd418, 10'd458, 10'd478, 10'd488, 10'd498, 10'd598 };
    localparam logic [TVOLT_BITS-1:0] RIGHT_VOLTS [RIGHT_COUNT] = '{
        13'd4400, 13'd4039, 13'd3974, 13'd3863, 13'd3770, 13'd3682, 13'd3645,
        13'd3611, 13'd3587, 13'd3548, 13'd3500, 13'd3438, 13'd3415, 13'd3392,
        13'd3230, 13'd3065, 13'd2400 };
    localparam logic [UNIT_BITS-1:0] RIGHT_UNITS [RIGHT_COUNT] = '{
        10'd0, 10'd100, 10'd118, 10'd158, 10'd198, 10'd238, 10'd278,
        10'd318, 10'd358, 10'd398, 10'd438, 10'd478, 10'd498, 10'd508,
        10'd528, 10'd538, 10'd638 };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SEARCH,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINAL,
        ST_DONE
    } bpv_state_t;

    typedef enum logic [1:0] {
        CONV_FULL,
        CONV_EMPTY,
        CONV_CUR
    } bpv_conv_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FULL_VOLTAGE,
        REG_EMPTY_VOLTAGE,
        REG_TABLE_SELECT
    } bpv_reg_t;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] full_voltage;
        logic [CFG_DATA_BITS-1:0] empty_voltage;
        logic                     table_select;
    } bpv_cfg_t;

    typedef struct packed {
        logic ready;
        logic done;
    } bpv_core_stat_t;

    function automatic logic [TVOLT_BITS-1:0] tbl_volts(input logic sel,
                                                        input logic [IDX_BITS-1:0] idx);
        logic [TVOLT_BITS-1:0] v;
        v = '0;
        if (sel)
        begin
            if (idx < IDX_BITS'(RIGHT_COUNT))
                v = RIGHT_VOLTS[idx];
        end
        else
        begin
            if (idx < IDX_BITS'(LEFT_COUNT))
                v = LEFT_VOLTS[idx[3:0]];
        end
        return v;
    endfunction

    function automatic logic [UNIT_BITS-1:0] tbl_units(input logic sel,
                                                       input logic [IDX_BITS-1:0] idx);
        logic [UNIT_BITS-1:0] u;
        u = '0;
        if (sel)
        begin
            if (idx < IDX_BITS'(RIGHT_COUNT))
                u = RIGHT_UNITS[idx];
        end
        else
        begin
            if (idx < IDX_BITS'(LEFT_COUNT))
                u = LEFT_UNITS[idx[3:0]];
        end
        return u;
    endfunction

    function automatic logic [IDX_BITS-1:0] tbl_last(input logic sel);
        return sel ? IDX_BITS'(RIGHT_COUNT - 1) : IDX_BITS'(LEFT_COUNT - 1);
    endfunction

endpackage

// ----- sv/bpv_if.sv -----
// Channel interfaces of the battery percentage unit: sample, result and configuration.
interface bpv_sample_if #(
    parameter int VOLTAGE_BITS = bpv_pkg::VOLTAGE_BITS_DEFAULT
);
    logic                    valid;
    logic                    ready;
    logic [VOLTAGE_BITS-1:0] voltage_mv;

    modport source (output valid, output voltage_mv, input ready);
    modport sink   (input valid, input voltage_mv, output ready);
endinterface

interface bpv_result_if;
    logic                         valid;
    logic                         ready;
    logic [bpv_pkg::PCT_BITS-1:0] percent;

    modport source (output valid, output percent, input ready);
    modport sink   (input valid, input percent, output ready);
endinterface

interface bpv_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [bpv_pkg::CFG_INDEX_BITS-1:0] index;
    logic [bpv_pkg::CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/bpv_divider.sv -----
// Restoring serial divider, one quotient bit per cycle.
module bpv_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [bpv_pkg::DIVIDEND_BITS-1:0]   dividend,
    input  logic [bpv_pkg::DIVISOR_BITS-1:0]    divisor,
    output logic                                done,
    output logic [bpv_pkg::DIVIDEND_BITS-1:0]   quotient
);

    localparam int DW = bpv_pkg::DIVIDEND_BITS;
    localparam int SW = bpv_pkg::DIVISOR_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          done_reg, done_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [SW-1:0] dvs_reg, dvs_next;
    logic [SW:0]   shifted;
    logic          fits;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = CW'(DW);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
            rem_next  = fits ? SW'(shifted - {1'b0, dvs_reg}) : shifted[SW-1:0];
            quo_next  = {quo_reg[DW-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/bpv_core.sv -----
// Sequencer: table walk, interpolation and percentage scaling over one shared divider.
module bpv_core #(
    parameter int VOLTAGE_BITS = bpv_pkg::VOLTAGE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bpv_pkg::bpv_cfg_t               cfg,
    input  logic                            start,
    input  logic [VOLTAGE_BITS-1:0]         voltage,
    input  logic                            take,
    output bpv_pkg::bpv_core_stat_t         stat,
    output logic [bpv_pkg::PCT_BITS-1:0]    pct
);

    localparam int VW  = bpv_pkg::VCMP_BITS;
    localparam int UW  = bpv_pkg::UNIT_BITS;
    localparam int IW  = bpv_pkg::IDX_BITS;
    localparam int DW  = bpv_pkg::DIVIDEND_BITS;
    localparam int SW  = bpv_pkg::DIVISOR_BITS;
    localparam int FW  = bpv_pkg::FACTOR_BITS;
    localparam int PW  = bpv_pkg::PCT_BITS;
    localparam logic [VW-1:0] VMASK = VW'((33'(1) << VOLTAGE_BITS) - 33'(1));

    bpv_pkg::bpv_state_t state_reg, state_next;
    bpv_pkg::bpv_conv_t  conv_reg, conv_next;
    logic                final_reg, final_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [VW-1:0]       cur_v_reg, cur_v_next;
    logic [UW-1:0]       full_u_reg, full_u_next;
    logic [UW-1:0]       empty_u_reg, empty_u_next;
    logic [UW-1:0]       cur_u_reg, cur_u_next;
    logic [UW-1:0]       base_reg, base_next;
    logic [SW-1:0]       mul_a_reg, mul_a_next;
    logic [FW-1:0]       mul_b_reg, mul_b_next;
    logic [SW-1:0]       dvs_reg, dvs_next;
    logic [DW-1:0]       prod_reg, prod_next;
    logic [PW-1:0]       pct_reg, pct_next;

    logic [VW-1:0]       v_sel;
    logic [VW-1:0]       v_hi, v_lo, v_first, v_diff;
    logic [UW-1:0]       u_hi, u_lo, u_step;
    logic [IW-1:0]       idx_prev;
    logic                store_en;
    logic [UW-1:0]       store_val;
    logic signed [UW:0]  span_d, span_n;
    logic [SW-1:0]       abs_d, abs_n;
    logic                div_start, div_done;
    logic [DW-1:0]       div_q;

    bpv_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Voltage under conversion and table reads at the search index
    always_comb
    begin
        unique case (conv_reg)
            bpv_pkg::CONV_FULL:  v_sel = VW'(cfg.full_voltage) & VMASK;
            bpv_pkg::CONV_EMPTY: v_sel = VW'(cfg.empty_voltage) & VMASK;
            default:             v_sel = cur_v_reg;
        endcase
        idx_prev = idx_reg - IW'(1);
        v_first  = VW'(bpv_pkg::tbl_volts(cfg.table_select, '0));
        v_hi     = VW'(bpv_pkg::tbl_volts(cfg.table_select, idx_prev));
        v_lo     = VW'(bpv_pkg::tbl_volts(cfg.table_select, idx_reg));
        u_hi     = bpv_pkg::tbl_units(cfg.table_select, idx_reg);
        u_lo     = bpv_pkg::tbl_units(cfg.table_select, idx_prev);
        v_diff   = v_hi - v_sel;
        u_step   = u_hi - u_lo;
        span_d   = $signed({1'b0, full_u_reg}) - $signed({1'b0, empty_u_reg});
        span_n   = $signed({1'b0, cur_u_reg}) - $signed({1'b0, empty_u_reg});
        abs_d    = span_d[UW] ? SW'(-span_d) : SW'(span_d);
        abs_n    = span_n[UW] ? SW'(-span_n) : SW'(span_n);
    end

    always_comb
    begin
        state_next   = state_reg;
        conv_next    = conv_reg;
        final_next   = final_reg;
        idx_next     = idx_reg;
        cur_v_next   = cur_v_reg;
        base_next    = base_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        dvs_next     = dvs_reg;
        pct_next     = pct_reg;
        prod_next    = {{(DW-SW){1'b0}}, mul_a_reg} * {{(DW-FW){1'b0}}, mul_b_reg};
        full_u_next  = full_u_reg;
        empty_u_next = empty_u_reg;
        cur_u_next   = cur_u_reg;
        store_en     = 1'b0;
        store_val    = '0;
        div_start    = 1'b0;

        unique case (state_reg)
            bpv_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cur_v_next = VW'(voltage);
                    conv_next  = bpv_pkg::CONV_FULL;
                    final_next = 1'b0;
                    state_next = bpv_pkg::ST_CHECK;
                end
            end
            bpv_pkg::ST_CHECK:
            begin
                if (v_sel > v_first)
                begin
                    store_en  = 1'b1;
                    store_val = '0;
                end
                else
                begin
                    idx_next   = IW'(1);
                    state_next = bpv_pkg::ST_SEARCH;
                end
            end
            bpv_pkg::ST_SEARCH:
            begin
                if (v_lo < v_sel)
                begin
                    mul_a_next = v_diff[SW-1:0];
                    mul_b_next = u_step[FW-1:0];
                    dvs_next   = SW'(v_hi - v_lo);
                    base_next  = u_lo;
                    state_next = bpv_pkg::ST_MUL;
                end
                else if (idx_reg == bpv_pkg::tbl_last(cfg.table_select))
                begin
                    store_en  = 1'b1;
                    store_val = u_hi;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            bpv_pkg::ST_MUL:
            begin
                state_next = bpv_pkg::ST_DIV_GO;
            end
            bpv_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = bpv_pkg::ST_DIV_WAIT;
            end
            bpv_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (final_reg)
                    begin
                        pct_next   = (div_q >= DW'(bpv_pkg::PCT_SCALE)) ? bpv_pkg::PCT_MAX
                                                                        : div_q[PW-1:0] + PW'(1);
                        state_next = bpv_pkg::ST_DONE;
                    end
                    else
                    begin
                        store_en  = 1'b1;
                        store_val = base_reg + div_q[UW-1:0];
                    end
                end
            end
            bpv_pkg::ST_FINAL:
            begin
                // Zero span gives the midpoint; a negative or zero ratio gives the floor
                if (span_d == '0)
                begin
                    pct_next   = bpv_pkg::PCT_MID;
                    state_next = bpv_pkg::ST_DONE;
                end
                else if (span_n == '0 || (span_d[UW] ^ span_n[UW]))
                begin
                    pct_next   = bpv_pkg::PCT_MIN;
                    state_next = bpv_pkg::ST_DONE;
                end
                else
                begin
                    mul_a_next = abs_n;
                    mul_b_next = FW'(bpv_pkg::PCT_SCALE);
                    dvs_next   = abs_d;
                    final_next = 1'b1;
                    state_next = bpv_pkg::ST_MUL;
                end
            end
            bpv_pkg::ST_DONE:
            begin
                if (take)
                    state_next = bpv_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bpv_pkg::ST_IDLE;
            end
        endcase

        // Deposit the units of this conversion and advance to the next one
        if (store_en)
        begin
            case (conv_reg)
                bpv_pkg::CONV_FULL:
                begin
                    full_u_next = store_val;
                    conv_next   = bpv_pkg::CONV_EMPTY;
                    state_next  = bpv_pkg::ST_CHECK;
                end
                bpv_pkg::CONV_EMPTY:
                begin
                    empty_u_next = store_val;
                    conv_next    = bpv_pkg::CONV_CUR;
                    state_next   = bpv_pkg::ST_CHECK;
                end
                default:
                begin
                    cur_u_next = store_val;
                    state_next = bpv_pkg::ST_FINAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpv_pkg::ST_IDLE;
            conv_reg  <= bpv_pkg::CONV_FULL;
            final_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            conv_reg  <= conv_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_v_reg   <= cur_v_next;
        full_u_reg  <= full_u_next;
        empty_u_reg <= empty_u_next;
        cur_u_reg   <= cur_u_next;
        base_reg    <= base_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        dvs_reg     <= dvs_next;
        prod_reg    <= prod_next;
        pct_reg     <= pct_next;
    end

    assign stat.ready = (state_reg == bpv_pkg::ST_IDLE);
    assign stat.done  = (state_reg == bpv_pkg::ST_DONE);
    assign pct        = pct_reg;

`ifndef NO_ASSERTIONS
    a_div_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == bpv_pkg::ST_DIV_WAIT)
        else $error("divider finished outside the wait state");
    a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> state_reg == bpv_pkg::ST_DIV_WAIT && !div_done)
        else $error("divider start not followed by a wait");
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> pct_reg >= bpv_pkg::PCT_MIN && pct_reg <= bpv_pkg::PCT_MAX)
        else $error("percentage outside its range");
`endif

endmodule

// ----- sv/battery_percent_from_voltage_unit.sv -----
// Top level of the battery percentage unit: configuration registers, core and result register.
//
// Usage:
//   sample : one beat carries voltage_mv; taken when valid and ready are high.
//   result : one beat per sample carries percent (1..100).
//   cfg    : index 0 full_voltage, 1 empty_voltage, 2 table_select; always ready.
//            Write only while no sample is in flight.
// Operation: each of the three voltage-to-units conversions walks the selected
//   table one entry per cycle (up to 16) and runs at most one pass of the
//   shared serial divider; the final scaling takes at most one more division.
//   No new sample is taken before the last one is finished; sample.ready is high
//   only while the sequencer is idle.
// Reset: the registers return to 4150 mV, 3000 mV and the left table, the
//   sequencer goes idle and the result register empties.
// Stall: a finished percentage waits in the result register; once the core
//   has a second one ready it holds until the register frees, and no new
//   sample is taken until then.
module battery_percent_from_voltage_unit #(
    parameter int VOLTAGE_BITS = bpv_pkg::VOLTAGE_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    bpv_sample_if.sink  sample,
    bpv_result_if.source result,
    bpv_cfg_if.sink     cfg
);

    bpv_pkg::bpv_cfg_t       cfg_reg, cfg_next;
    bpv_pkg::bpv_core_stat_t core_stat;
    logic                    out_valid_reg, out_valid_next;
    logic [bpv_pkg::PCT_BITS-1:0] percent_reg, percent_next;
    logic [bpv_pkg::PCT_BITS-1:0] core_pct;
    logic                    out_free;
    logic                    load;

    // Configuration writes: decode the index, drop writes beyond the list
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                bpv_pkg::REG_FULL_VOLTAGE:  cfg_next.full_voltage  = cfg.data;
                bpv_pkg::REG_EMPTY_VOLTAGE: cfg_next.empty_voltage = cfg.data;
                bpv_pkg::REG_TABLE_SELECT:  cfg_next.table_select  = cfg.data[0];
                default:                    cfg_next               = cfg_reg;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // Hand a sample to the core only while it is idle
    assign sample.ready = core_stat.ready;

    bpv_core #(
        .VOLTAGE_BITS (VOLTAGE_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .start   (sample.valid),
        .voltage (sample.voltage_mv),
        .take    (out_free),
        .stat    (core_stat),
        .pct     (core_pct)
    );

    // Result register: load when empty or being drained in the same cycle
    always_comb
    begin
        out_free       = !out_valid_reg || result.ready;
        load           = core_stat.done && out_free;
        out_valid_next = out_valid_reg;
        percent_next   = percent_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            percent_next   = core_pct;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_voltage  <= bpv_pkg::FULL_VOLTAGE_RESET;
            cfg_reg.empty_voltage <= bpv_pkg::EMPTY_VOLTAGE_RESET;
            cfg_reg.table_select  <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        percent_reg <= percent_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.percent = percent_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("sample taken while a conversion was running");
    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done && out_free |=> result.valid && result.percent == $past(core_pct))
        else $error("finished percentage not presented");
    a_done_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> !sample.ready)
        else $error("core ready while holding a result");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of battery_percent_from_voltage_unit: predicted percentages against results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpv_pkg::*;

    localparam int VBITS = VOLTAGE_BITS_DEFAULT;
    // Margin after a drain for the block to go idle before touching registers.
    localparam int SETTLE_CYCLES = 200;
    // No beat on any channel for this long means the block has hung.
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_GAP = 12;

    // One outstanding percentage, with the sample that caused it for the report.
    typedef struct {
        logic [VBITS-1:0]    voltage;
        logic [PCT_BITS-1:0] percent;
    } owed_beat_t;

    // Scoreboard: keeps its own copy of the registers, predicts each percentage
    // when a sample beat is taken and compares result beats in order.
    class percent_board;
        logic [CFG_DATA_BITS-1:0] full_mv;
        logic [CFG_DATA_BITS-1:0] empty_mv;
        logic                     sel;
        owed_beat_t               owed[$];
        int errors;
        int samples;
        int n_low;
        int n_mid;
        int n_high;
        int n_other;

        function new();
            full_mv  = FULL_VOLTAGE_RESET;
            empty_mv = EMPTY_VOLTAGE_RESET;
            sel      = 1'b0;
            errors   = 0;
            samples  = 0;
            n_low    = 0;
            n_mid    = 0;
            n_high   = 0;
            n_other  = 0;
        endfunction

        function int volt_at(logic s, int i);
            if (s)
                return int'(RIGHT_VOLTS[i]);
            return int'(LEFT_VOLTS[i]);
        endfunction

        function int unit_at(logic s, int i);
            if (s)
                return int'(RIGHT_UNITS[i]);
            return int'(LEFT_UNITS[i]);
        endfunction

        // Elapsed discharge units for a voltage on the selected curve.
        function int units_at(int v);
            int count;
            int hi;
            int lo;
            int du;
            count = sel ? RIGHT_COUNT : LEFT_COUNT;
            if (v > volt_at(sel, 0))
                return 0;
            for (int i = 1; i < count; i++)
            begin
                if (volt_at(sel, i) < v)
                begin
                    hi = volt_at(sel, i - 1);
                    lo = volt_at(sel, i);
                    du = unit_at(sel, i) - unit_at(sel, i - 1);
                    return unit_at(sel, i - 1) + ((hi - v) * du) / (hi - lo);
                end
            end
            return unit_at(sel, count - 1);
        endfunction

        function logic [PCT_BITS-1:0] predict_percent(logic [VBITS-1:0] v);
            int fu;
            int eu;
            int cu;
            int d;
            int n;
            int p;
            fu = units_at(int'(full_mv));
            eu = units_at(int'(empty_mv));
            cu = units_at(int'(v));
            d  = fu - eu;
            n  = (cu - eu) * int'(PCT_SCALE);
            if (d == 0)
                p = int'(PCT_MID);
            else
            begin
                if (d < 0)
                begin
                    d = -d;
                    n = -n;
                end
                if (n < 0)
                    p = int'(PCT_MIN);
                else
                begin
                    p = int'(PCT_MIN) + n / d;
                    if (p > int'(PCT_MAX))
                        p = int'(PCT_MAX);
                end
            end
            return p[PCT_BITS-1:0];
        endfunction

        function void set_reg(bpv_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_FULL_VOLTAGE:  full_mv  = data;
                REG_EMPTY_VOLTAGE: empty_mv = data;
                REG_TABLE_SELECT:  sel      = data[0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [VBITS-1:0] v);
            owed_beat_t b;
            b.voltage = v;
            b.percent = predict_percent(v);
            owed.push_back(b);
            samples++;
        endfunction

        function void check_percent(logic [PCT_BITS-1:0] got);
            owed_beat_t b;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, got %0d", $time, got);
                errors++;
                return;
            end
            b = owed.pop_front();
            if (got !== b.percent)
            begin
                $display("%0t: percent for %0d mV: expected %0d, got %0d",
                         $time, b.voltage, b.percent, got);
                errors++;
            end
            if (b.percent == PCT_MIN)
                n_low++;
            else if (b.percent == PCT_MID)
                n_mid++;
            else if (b.percent == PCT_MAX)
                n_high++;
            else
                n_other++;
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bpv_sample_if #(.VOLTAGE_BITS(VBITS)) sample_ch();
    bpv_result_if                         result_ch();
    bpv_cfg_if                            cfg_ch();

    battery_percent_from_voltage_unit #(.VOLTAGE_BITS(VBITS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    percent_board board = new();

    // When set, both sides run flat out with no idle cycles.
    bit steady = 1'b0;
    int settings_done = 0;
    int quiet = 0;

    always #5ns clk = ~clk;

    // Hold every input at a known value from time zero.
    initial
    begin
        sample_ch.valid      <= 1'b0;
        sample_ch.voltage_mv <= '0;
        result_ch.ready      <= 1'b0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_FULL_VOLTAGE;
        cfg_ch.data          <= '0;
    end

    // Watchdog: restart the count on any beat, give up after a long silence.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: draw a stall per beat, drop ready for it, then take the beat
    // and hand it to the scoreboard. Ready stays high across back-to-back beats.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            board.check_percent(result_ch.percent);
        end
    end

    // Offer one sample beat after a random gap; valid is left high afterwards so
    // that a zero gap gives back-to-back beats without a glitch.
    task automatic send_sample(input logic [VBITS-1:0] v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.voltage_mv <= v;
        do @(posedge clk); while (!sample_ch.ready);
        board.note_sample(v);
    endtask

    // Stop offering samples and hold until every owed percentage has come back.
    task automatic drain();
        if (sample_ch.valid)
            sample_ch.valid <= 1'b0;
        while (board.owed.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input bpv_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        board.set_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Registers change only with the block idle: drain, let it settle, write all three.
    task automatic apply_setting(input int full_mv, input int empty_mv, input int sel);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(REG_FULL_VOLTAGE, full_mv[CFG_DATA_BITS-1:0]);
        cfg_write(REG_EMPTY_VOLTAGE, empty_mv[CFG_DATA_BITS-1:0]);
        cfg_write(REG_TABLE_SELECT, sel[CFG_DATA_BITS-1:0]);
        settings_done++;
    endtask

    // Mostly voltages on the curve, a share right on or beside a breakpoint or
    // a register voltage, and some anywhere in the 13-bit range.
    function automatic logic [VBITS-1:0] pick_voltage();
        int r;
        int i;
        int v;
        r = $urandom_range(0, 99);
        if (r < 15)
            v = $urandom_range(0, (1 << VBITS) - 1);
        else if (r < 40)
        begin
            if (board.sel)
            begin
                i = $urandom_range(0, RIGHT_COUNT - 1);
                v = int'(RIGHT_VOLTS[i]);
            end
            else
            begin
                i = $urandom_range(0, LEFT_COUNT - 1);
                v = int'(LEFT_VOLTS[i]);
            end
            v = v + int'($urandom_range(0, 2)) - 1;
        end
        else if (r < 50)
        begin
            v = ($urandom_range(0, 1) != 0) ? int'(board.full_mv) : int'(board.empty_mv);
            v = v + int'($urandom_range(0, 6)) - 3;
            if (v < 0)
                v = 0;
            if (v > (1 << VBITS) - 1)
                v = (1 << VBITS) - 1;
        end
        else
            v = $urandom_range(1500, 4600);
        return v[VBITS-1:0];
    endfunction

    // Random samples; now and then pause the sender until the pipe is empty.
    task automatic run_random(input int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 39) == 0)
                drain();
            send_sample(pick_voltage());
        end
    endtask

    task automatic run_list(input int volts[$]);
        foreach (volts[k])
            send_sample(volts[k][VBITS-1:0]);
    endtask

    initial
    begin
        int corners[$];
        int full_mv;
        int empty_mv;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings (4150 mV full, 3000 mV empty, left curve): field
        // extremes, first and last breakpoints and their neighbours, the
        // register voltages themselves and a voltage far below the curve.
        corners = '{0, 8191, 1, 4096, 4288, 4289, 4287, 4022, 4021, 3999, 3998,
                    3629, 3168, 3167, 1678, 1677, 1679, 4150, 4151, 3000, 2999,
                    3500, 5000, 2048, 7000};
        run_list(corners);
        run_random(15);
        // Hold the sender once until every result is back, then carry on.
        drain();
        run_random(15);

        // Right curve with the widest span: full at the top, empty at zero.
        apply_setting(8191, 0, 1);
        corners = '{0, 8191, 4400, 4401, 4399, 2400, 2399, 3065, 3392};
        run_list(corners);
        run_random(30);

        // Reversed span: full below empty, so the mapping runs backwards.
        apply_setting(0, 8191, 0);
        corners = '{0, 8191, 4288, 1678, 3500, 4400};
        run_list(corners);
        run_random(30);

        // Degenerate spans: equal registers, both above the first breakpoint,
        // both below the last one. Every result must be the midpoint.
        apply_setting(3700, 3700, 1);
        run_random(20);
        apply_setting(5000, 4600, 0);
        run_random(20);
        apply_setting(1000, 0, 1);
        run_random(20);
        // Equal units from different voltages, both just above the first breakpoint.
        apply_setting(4500, 4401, 1);
        run_random(10);

        // Random settings; every fourth phase runs with no idle cycles.
        for (int ph = 0; ph < 12; ph++)
        begin
            if ($urandom_range(0, 3) == 0)
                full_mv = $urandom_range(0, (1 << CFG_DATA_BITS) - 1);
            else
                full_mv = $urandom_range(3300, 4500);
            if ($urandom_range(0, 3) == 0)
                empty_mv = $urandom_range(0, (1 << CFG_DATA_BITS) - 1);
            else
                empty_mv = $urandom_range(1500, 3700);
            apply_setting(full_mv, empty_mv, $urandom_range(0, 1));
            steady = ((ph % 4) == 3);
            run_random(150);
        end
        steady = 1'b0;

        // Wait out the last results, then allow a quiet tail for strays.
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb: %0d samples checked over %0d register settings on both curves",
                 board.samples, settings_done);
        $display("tb: results at 1 percent %0d, midpoint %0d, 100 percent %0d, between %0d",
                 board.n_low, board.n_mid, board.n_high, board.n_other);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
